// File: src/sse_data_event_deframer_assert.svh
// Assertion macros shared by the SSE data event deframer modules.
`ifndef SSE_DATA_EVENT_DEFRAMER_ASSERT_SVH
`define SSE_DATA_EVENT_DEFRAMER_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define SDD_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sdd assertion failed");

// Consequent holds in the cycle after the antecedent.
`define SDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdd assertion failed");

`endif

// File: src/sdd_pkg.sv
// Types and constants for the SSE data event deframer.
`default_nettype none

package sdd_pkg;

    localparam logic [2:0] PH_START   = 3'd0;
    localparam logic [2:0] PH_COLON   = 3'd5;
    localparam logic [2:0] PH_PAYLOAD = 3'd6;
    localparam logic [2:0] PH_IGNORE  = 3'd7;

    localparam logic       CMD_BYTE = 1'b0;
    localparam logic       CMD_EOS  = 1'b1;

    localparam logic       KIND_BYTE = 1'b0;
    localparam logic       KIND_END  = 1'b1;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_D     = 8'h64;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic       last;
    } entry_t;

    typedef struct packed {
        logic [1:0]       cnt;
        entry_t [1:0]     ent;
    } res_t;

    // Expected byte of "data:" after that many bytes matched.
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h64;
            3'd1:    c = 8'h61;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h61;
            3'd4:    c = 8'h3A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: src/sdd_parser.sv
// Line parser: tracks line phase and held CR, produces up to two results per request.
`default_nettype none

module sdd_parser (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic          cmd,
    input  wire logic [7:0]    in_byte,
    output sdd_pkg::res_t      res
);
    import sdd_pkg::*;

    `include "sse_data_event_deframer_assert.svh"

    logic [2:0] phase_reg, phase_next;
    logic       cr_reg, cr_next;
    logic       have_reg, have_next;

    function automatic entry_t mk(input logic kind, input logic [7:0] value);
        entry_t e;
        e.kind  = kind;
        e.value = value;
        e.last  = 1'b0;
        return e;
    endfunction

    always_comb
    begin
        res        = '0;
        phase_next = phase_reg;
        cr_next    = cr_reg;
        have_next  = have_reg;
        if (cmd == CMD_EOS)
        begin
            if (have_reg)
            begin
                res.ent[0] = mk(KIND_END, 8'h00);
                res.cnt    = 2'd1;
            end
            phase_next = PH_START;
            cr_next    = 1'b0;
            have_next  = 1'b0;
        end
        else if (in_byte == CHAR_LF)
        begin
            if (phase_reg == PH_START && have_reg)
            begin
                res.ent[0] = mk(KIND_END, 8'h00);
                res.cnt    = 2'd1;
                have_next  = 1'b0;
            end
            phase_next = PH_START;
            cr_next    = 1'b0;
        end
        else
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (cr_reg)
                    begin
                        cr_next    = 1'b0;
                        phase_next = PH_IGNORE;
                    end
                    else if (in_byte == CHAR_CR)
                        cr_next = 1'b1;
                    else if (in_byte == CHAR_D)
                        phase_next = 3'd1;
                    else
                        phase_next = PH_IGNORE;
                end
                PH_COLON:
                begin
                    phase_next = PH_PAYLOAD;
                    if (in_byte == CHAR_CR)
                        cr_next = 1'b1;
                    else if (in_byte != CHAR_SPACE)
                    begin
                        res.ent[0] = mk(KIND_BYTE, in_byte);
                        res.cnt    = 2'd1;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (cr_reg)
                    begin
                        res.ent[0] = mk(KIND_BYTE, CHAR_CR);
                        if (in_byte == CHAR_CR)
                            res.cnt = 2'd1;
                        else
                        begin
                            cr_next    = 1'b0;
                            res.ent[1] = mk(KIND_BYTE, in_byte);
                            res.cnt    = 2'd2;
                        end
                    end
                    else if (in_byte == CHAR_CR)
                        cr_next = 1'b1;
                    else
                    begin
                        res.ent[0] = mk(KIND_BYTE, in_byte);
                        res.cnt    = 2'd1;
                    end
                end
                PH_IGNORE:
                    cr_next = 1'b0;
                default:
                begin
                    // matching "data:" prefix
                    if (in_byte == prefix_char(phase_reg))
                    begin
                        phase_next = phase_reg + 3'd1;
                        if (phase_reg == 3'd4)
                        begin
                            if (have_reg)
                            begin
                                res.ent[0] = mk(KIND_BYTE, CHAR_LF);
                                res.cnt    = 2'd1;
                            end
                            have_next = 1'b1;
                        end
                    end
                    else
                        phase_next = PH_IGNORE;
                end
            endcase
        end
        if (res.cnt == 2'd1)
            res.ent[0].last = 1'b1;
        else if (res.cnt == 2'd2)
            res.ent[1].last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            cr_reg    <= 1'b0;
            have_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            cr_reg    <= cr_next;
            have_reg  <= have_next;
        end
    end

    `SDD_ASSERT_ALWAYS(a_cr_phase, clk, rst_n,
        !cr_reg || phase_reg == PH_START || phase_reg == PH_PAYLOAD)
    `SDD_ASSERT_NEXT(a_eos_reset, clk, rst_n, step && cmd == CMD_EOS,
        phase_reg == PH_START && !cr_reg && !have_reg)

endmodule

`default_nettype wire

// File: src/sse_data_event_deframer.sv
// Accepted results are registered in the queue and offered after older results.
// Throughput: one request per cycle while results drain at one per cycle;
// a request that yields two results writes both into the queue together.
// Results wait in a four-entry queue; input is ready while it holds two or fewer.
// Reset (rst_n, async low) empties the queue and returns the parser to line start.
`default_nettype none

module sse_data_event_deframer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       cmd,
    input  wire logic [7:0] in_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            out_kind,
    output logic [7:0]      out_byte,
    output logic            out_last
);
    import sdd_pkg::*;

    `include "sse_data_event_deframer_assert.svh"

    localparam int DEPTH = 4;

    res_t       res;
    logic       push;
    logic       pop;
    entry_t     q_mem [DEPTH];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg, count_next;
    logic [1:0] push_cnt;
    entry_t     head;

    assign in_ready = (count_reg <= 3'd2);
    assign push     = in_valid && in_ready;
    assign pop      = out_valid && out_ready;
    assign push_cnt = push ? res.cnt : 2'd0;

    sdd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (push),
        .cmd     (cmd),
        .in_byte (in_byte),
        .res     (res)
    );

    assign count_next = count_reg + {1'b0, push_cnt} - {2'b00, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push_cnt;
            rd_ptr_reg <= rd_ptr_reg + {1'b0, pop};
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && res.cnt != 2'd0)
            q_mem[wr_ptr_reg] <= res.ent[0];
        if (push && res.cnt == 2'd2)
            q_mem[wr_ptr_reg + 2'd1] <= res.ent[1];
    end

    assign head      = q_mem[rd_ptr_reg];
    assign out_valid = (count_reg != 3'd0);
    assign out_kind  = head.kind;
    assign out_byte  = head.value;
    assign out_last  = head.last;

    `SDD_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= 3'(DEPTH))
    `SDD_ASSERT_ALWAYS(a_end_zero, clk, rst_n,
        !(out_valid && out_kind == KIND_END) || out_byte == 8'h00)

endmodule

`default_nettype wire

// File: tb/sv/sse_data_event_deframer_tb.sv
// Self-checking testbench for the SSE data event deframer: byte stream in, payload and event ends out.
module sse_data_event_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sdd_pkg::*;

    typedef struct packed {
        logic       op;
        logic [7:0] value;
    } stream_item_t;

    localparam logic [7:0] DATA_TAG [0:4] = '{8'h64, 8'h61, 8'h74, 8'h61, 8'h3A};
    localparam int RANDOM_TARGET = 1800;
    localparam int REPORT_LIMIT = 10;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       cmd = CMD_BYTE;
    logic [7:0] in_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       out_kind;
    logic [7:0] out_byte;
    logic       out_last;

    stream_item_t stream_q [$];
    entry_t       deframed_q [$];

    // Parser state mirrored from the block.
    logic [2:0] phase = PH_START;
    logic       cr_held = 1'b0;
    logic       in_event = 1'b0;

    int total_reqs = 0;
    int accepted_reqs = 0;
    int eos_reqs = 0;
    int seen_results = 0;
    int events_closed = 0;
    int fault_count = 0;
    int send_wait = 0;
    int recv_wait = 0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;

    sse_data_event_deframer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_kind  (out_kind),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, 5);
    endfunction

    task automatic add_result(input logic kind, input logic [7:0] value);
        entry_t e;
        e.kind = kind;
        e.value = value;
        e.last = 1'b0;
        deframed_q.push_back(e);
        if (kind == KIND_END)
            events_closed++;
    endtask

    // Advance the parser by one request and queue the results it yields.
    task automatic deframe_request(input logic op, input logic [7:0] b);
        int base;
        base = deframed_q.size();
        if (op == CMD_EOS)
        begin
            if (in_event)
                add_result(KIND_END, 8'h00);
            phase = PH_START;
            cr_held = 1'b0;
            in_event = 1'b0;
        end
        else if (b == CHAR_LF)
        begin
            if (phase == PH_START && in_event)
            begin
                add_result(KIND_END, 8'h00);
                in_event = 1'b0;
            end
            phase = PH_START;
            cr_held = 1'b0;
        end
        else
        begin
            case (phase)
                PH_START:
                begin
                    // a held CR not followed by LF makes the line non-empty
                    if (cr_held)
                    begin
                        cr_held = 1'b0;
                        phase = PH_IGNORE;
                    end
                    else if (b == CHAR_CR)
                        cr_held = 1'b1;
                    else if (b == DATA_TAG[0])
                        phase = 3'd1;
                    else
                        phase = PH_IGNORE;
                end
                PH_COLON:
                begin
                    phase = PH_PAYLOAD;
                    if (b == CHAR_CR)
                        cr_held = 1'b1;
                    else if (b != CHAR_SPACE)
                        add_result(KIND_BYTE, b);
                end
                PH_PAYLOAD:
                begin
                    if (cr_held)
                    begin
                        add_result(KIND_BYTE, CHAR_CR);
                        if (b != CHAR_CR)
                        begin
                            cr_held = 1'b0;
                            add_result(KIND_BYTE, b);
                        end
                    end
                    else if (b == CHAR_CR)
                        cr_held = 1'b1;
                    else
                        add_result(KIND_BYTE, b);
                end
                PH_IGNORE:
                    cr_held = 1'b0;
                default:
                begin
                    if (b == DATA_TAG[phase])
                    begin
                        phase = phase + 3'd1;
                        if (phase == PH_COLON)
                        begin
                            if (in_event)
                                add_result(KIND_BYTE, CHAR_LF);
                            in_event = 1'b1;
                        end
                    end
                    else
                        phase = PH_IGNORE;
                end
            endcase
        end
        if (deframed_q.size() > base)
            deframed_q[deframed_q.size() - 1].last = 1'b1;
    endtask

    task automatic push_byte(input logic [7:0] b);
        stream_q.push_back('{CMD_BYTE, b});
    endtask

    task automatic push_eos(input logic [7:0] b);
        stream_q.push_back('{CMD_EOS, b});
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    function automatic logic [7:0] payload_byte();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            return CHAR_CR;
        else if (pick < 18)
            return CHAR_LF;
        else if (pick < 24)
            return CHAR_SPACE;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic push_payload(input int max_len);
        int len;
        len = ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, max_len);
        repeat (len) push_byte(payload_byte());
    endtask

    task automatic end_line();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            push_byte(CHAR_LF);
        else if (pick < 85)
        begin
            push_byte(CHAR_CR);
            push_byte(CHAR_LF);
        end
        else if (pick < 93)
            push_eos(8'($urandom_range(0, 255)));
        else
        begin
            push_byte(CHAR_CR);
            push_eos(8'($urandom_range(0, 255)));
        end
    endtask

    // Mostly well-formed data lines; the rest is blank lines, other fields, noise and bare end-of-stream requests.
    task automatic push_random_line();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            push_text("data:");
            if ($urandom_range(0, 1) == 1)
                push_byte(CHAR_SPACE);
            push_payload(10);
            end_line();
        end
        else if (pick < 67)
        begin
            if ($urandom_range(0, 2) == 0)
                push_byte(CHAR_CR);
            push_byte(CHAR_LF);
        end
        else if (pick < 75)
        begin
            if (pick < 71)
                push_text("event:");
            else
                push_text("id: ");
            push_payload(6);
            end_line();
        end
        else if (pick < 79)
        begin
            push_byte(DATA_TAG[4]);
            push_payload(6);
            end_line();
        end
        else if (pick < 87)
        begin
            case ($urandom_range(0, 3))
                0: push_text("dat");
                1: push_text("Data:");
                2: push_text("datA:");
                default: push_text(" data:");
            endcase
            push_payload(4);
            end_line();
        end
        else if (pick < 95)
        begin
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
            end_line();
        end
        else
            push_eos(8'($urandom_range(0, 255)));
    endtask

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
            $display("ERROR: %s", msg);
    endtask

    // Driver: hold a request until accepted, then wait a drawn number of cycles.
    always @(posedge clk)
    begin : driver
        bit holding;
        stream_item_t item;
        if (rst_n)
        begin
            holding = 1'b0;
            if (in_valid && in_ready)
            begin
                deframe_request(cmd, in_byte);
                accepted_reqs++;
                if (cmd == CMD_EOS)
                    eos_reqs++;
                if ($urandom_range(0, 49) == 0)
                    send_calm = !send_calm;
                send_wait = draw_wait(send_calm);
            end
            else
                holding = in_valid;
            if (!holding)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    in_valid <= 1'b0;
                end
                else if (stream_q.size() > 0)
                begin
                    item = stream_q.pop_front();
                    in_valid <= 1'b1;
                    cmd <= item.op;
                    in_byte <= item.value;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted result with the oldest expected one.
    always @(posedge clk)
    begin : monitor
        entry_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                seen_results++;
                if (deframed_q.size() == 0)
                    note_fault($sformatf("unexpected result %0d: kind %0b byte %02h last %0b",
                        seen_results, out_kind, out_byte, out_last));
                else
                begin
                    want = deframed_q.pop_front();
                    if (out_kind !== want.kind || out_byte !== want.value
                        || out_last !== want.last)
                        note_fault($sformatf(
                            "result %0d: kind %0b/%0b byte %02h/%02h last %0b/%0b (exp/got)",
                            seen_results, want.kind, out_kind, want.value, out_byte,
                            want.last, out_last));
                end
                if ($urandom_range(0, 49) == 0)
                    recv_calm = !recv_calm;
                recv_wait = draw_wait(recv_calm);
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        // blank line with no event open
        push_byte(CHAR_LF);
        // CR at line start followed by a plain byte: line ignored
        push_byte(CHAR_CR);
        push_byte(8'h00);
        push_byte(CHAR_LF);
        // empty data line opens an event
        push_text("data:");
        push_byte(CHAR_LF);
        // CR after the colon, CR pairs in the payload, CR before LF dropped
        push_text("data:");
        push_byte(CHAR_CR);
        push_byte(CHAR_CR);
        push_byte(8'hFF);
        push_byte(CHAR_CR);
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
        // CR LF blank line closes the event
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
        // space dropped, held CR dropped by end of stream
        push_text("data: ");
        push_byte(CHAR_CR);
        push_eos(8'h00);
        // end of stream with nothing open
        push_eos(8'hFF);
        while (stream_q.size() < 32 + RANDOM_TARGET)
            push_random_line();
        total_reqs = stream_q.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_reqs < total_reqs)
            @(posedge clk);
        while (deframed_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d requests (%0d end-of-stream), checked %0d results, %0d events closed.",
            accepted_reqs, eos_reqs, seen_results, events_closed);
        $display("Mismatches: %0d", fault_count);
        if (fault_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Timeout with %0d of %0d requests accepted, %0d results outstanding",
            accepted_reqs, total_reqs, deframed_q.size());
        $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/sdd_pkg.sv
src/sdd_parser.sv
src/sse_data_event_deframer.sv
tb/sv/sse_data_event_deframer_tb.sv
